/* rtl/core/php_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// php_pkg
// Shared types and constants of the packet header parser.
// ----------------------------------------------------------------------------
package php_pkg;

  localparam int unsigned MaxVlanTags = 2;
  localparam int unsigned MaxExtHeaders = 8;
  localparam int unsigned LengthBits = 16;
  localparam logic [15:0] FrameLimit = 16'((32'd1 << LengthBits) - 32'd1);

  localparam logic [15:0] EtIpv4 = 16'h0800;
  localparam logic [15:0] EtIpv6 = 16'h86DD;
  localparam logic [15:0] EtVlan = 16'h8100;
  localparam logic [7:0] PrTcp = 8'd6;
  localparam logic [7:0] PrUdp = 8'd17;
  localparam logic [7:0] NhHopByHop = 8'd0;
  localparam logic [7:0] NhRouting = 8'd43;
  localparam logic [7:0] NhDestOpt = 8'd60;
  localparam logic [15:0] Ipv6HdrBytes = 16'd40;

  typedef enum logic [1:0] {
    LinkEthernet = 2'd0,
    LinkCookedV1 = 2'd1,
    LinkCookedV2 = 2'd2,
    LinkRawIp = 2'd3
  } php_link_e;

  typedef enum logic [2:0] {
    StOk = 3'd0,
    StTruncated = 3'd1,
    StUnsupported = 3'd2,
    StBadLength = 3'd3,
    StFragment = 3'd4,
    StProtocol = 3'd5,
    StEmpty = 3'd6
  } php_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic last;
  } php_in_t;

  typedef struct packed {
    php_status_e status;
    logic is_ipv6;
    logic is_udp;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic [63:0] dst_addr_high;
    logic [63:0] dst_addr_low;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
  } php_out_t;

  // per-frame summary handed from the byte parser to the result stage
  typedef struct packed {
    logic err;
    logic phase;
    logic [15:0] byte_index;
    logic [7:0] net_start;
    logic [15:0] ethertype;
    logic [7:0] ihl_bytes;
    logic [15:0] ip_len;
    logic [15:0] frag;
    logic [7:0] next_hdr;
    logic [3:0] ext_count;
    logic [15:0] ext_end;
    logic [15:0] trans_start;
    logic [7:0] tcp_bytes;
    logic [3:0][63:0] addr;
    logic [1:0][15:0] ports;
  } php_sum_t;

  function automatic logic is_ext_hdr(logic [7:0] nh);
    return (nh == NhHopByHop) || (nh == NhRouting) || (nh == NhDestOpt);
  endfunction

endpackage

/* rtl/core/php_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// php_front
// Byte parser: walks link, network and transport headers one byte per cycle
// and emits a frame summary on the last byte.
// ----------------------------------------------------------------------------
module php_front import php_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_valid_i,
  input  logic [1:0] cfg_data_i,
  input  logic byte_valid_i,
  input  php_in_t byte_i,
  output logic sum_valid_o,
  output php_sum_t sum_o
);

  logic [1:0] link_q, link_d, fl_q, fl_d;
  logic err_q, err_d, ph_q, ph_d;
  logic [15:0] idx_q, idx_d, et_q, et_d;
  logic [7:0] ep_q, ep_d, ns_q, ns_d, ihl_q, ihl_d, nh_q, nh_d, pend_q, pend_d;
  logic [7:0] tcp_q, tcp_d;
  logic [2:0] vlan_q, vlan_d;
  logic [15:0] iplen_q, iplen_d, frag_q, frag_d, ee_q, ee_d, ts_q, ts_d;
  logic [3:0] cnt_q, cnt_d;
  logic [3:0][63:0] addr_q, addr_d;
  logic [1:0][15:0] port_q, port_d;

  // header walk for the current byte
  always_comb begin
    logic [7:0] b;
    logic [15:0] r, t;
    logic tb_en;
    logic [1:0] k;
    b = byte_i.data_byte;
    r = '0;
    t = '0;
    tb_en = 1'b0;
    k = '0;
    link_d = cfg_valid_i ? cfg_data_i : link_q;
    fl_d = fl_q; err_d = err_q; ph_d = ph_q; idx_d = idx_q; et_d = et_q;
    ep_d = ep_q; ns_d = ns_q; ihl_d = ihl_q; nh_d = nh_q; pend_d = pend_q;
    tcp_d = tcp_q; vlan_d = vlan_q; iplen_d = iplen_q; frag_d = frag_q;
    ee_d = ee_q; ts_d = ts_q; cnt_d = cnt_q; addr_d = addr_q; port_d = port_q;
    if (byte_valid_i && !err_q) begin
      if (idx_q == FrameLimit) begin
        err_d = 1'b1;
      end else begin
        idx_d = idx_q + 16'd1;
        // link type is sampled on the first byte
        if (idx_q == 16'd0) begin
          fl_d = link_q;
          case (php_link_e'(link_q))
            LinkEthernet: begin ns_d = 8'd14; ep_d = 8'd12; end
            LinkCookedV1: begin ns_d = 8'd16; ep_d = 8'd14; end
            LinkCookedV2: begin ns_d = 8'd20; ep_d = 8'd0; end
            default: begin
              ns_d = 8'd0;
              ph_d = 1'b1;
              et_d = (b[7:4] == 4'd6) ? EtIpv6 : EtIpv4;
            end
          endcase
        end
        if (!ph_d) begin
          // link header and vlan tags
          if (idx_q == {8'd0, ep_d}) et_d = {b, 8'd0};
          else if ({1'b0, idx_q} == {9'd0, ep_d} + 17'd1) et_d = {et_d[15:8], b};
          if ({1'b0, idx_q} + 17'd1 == {9'd0, ns_d}) begin
            if (fl_d == LinkEthernet && et_d == EtVlan &&
                vlan_d < 3'(MaxVlanTags)) begin
              vlan_d = vlan_d + 3'd1;
              ns_d = ns_d + 8'd4;
              ep_d = ep_d + 8'd4;
            end else begin
              ph_d = 1'b1;
            end
          end
        end else if (idx_q >= {8'd0, ns_d}) begin
          r = idx_q - {8'd0, ns_d};
          if (et_d == EtIpv4) begin
            // ipv4 header fields
            if (r == 16'd0) begin
              ihl_d = {4'd0, b[3:0]} << 2;
              ts_d = {8'd0, ihl_d};
            end else if (r == 16'd2 || r == 16'd3) iplen_d = {iplen_d[7:0], b};
            else if (r == 16'd6 || r == 16'd7) frag_d = {frag_d[7:0], b};
            else if (r == 16'd9) nh_d = b;
            else if (r >= 16'd12 && r < 16'd16) addr_d[1] = {addr_d[1][55:0], b};
            else if (r >= 16'd16 && r < 16'd20) addr_d[3] = {addr_d[3][55:0], b};
            if (r >= ts_d) begin
              tb_en = 1'b1;
              t = r - ts_d;
            end
          end else if (et_d == EtIpv6) begin
            // ipv6 fixed header
            if (r == 16'd4 || r == 16'd5) iplen_d = {iplen_d[7:0], b};
            else if (r == 16'd6) nh_d = b;
            else if (r >= 16'd8 && r < 16'd40) begin
              k = 2'((r - 16'd8) >> 3);
              addr_d[k] = {addr_d[k][55:0], b};
            end
            // extension header chain
            if (r >= Ipv6HdrBytes && is_ext_hdr(nh_d) && cnt_d < 4'(MaxExtHeaders)) begin
              if (r == ee_d) pend_d = b;
              else if ({1'b0, r} == {1'b0, ee_d} + 17'd1) begin
                ee_d = ee_d + {4'd0, ({1'b0, b} + 9'd1), 3'd0};
                nh_d = pend_d;
                cnt_d = cnt_d + 4'd1;
              end
            end else if (r >= ee_d && (nh_d == PrTcp || nh_d == PrUdp)) begin
              ts_d = ee_d;
              tb_en = 1'b1;
              t = r - ee_d;
            end
          end
        end
        // transport ports and data offset
        if (tb_en) begin
          if (t < 16'd4) port_d[t[1]] = {port_d[t[1]][7:0], b};
          else if (t == 16'd12) tcp_d = {2'd0, b[7:4], 2'd0};
        end
      end
    end
    sum_o.err = err_d;
    sum_o.phase = ph_d;
    sum_o.byte_index = idx_d;
    sum_o.net_start = ns_d;
    sum_o.ethertype = et_d;
    sum_o.ihl_bytes = ihl_d;
    sum_o.ip_len = iplen_d;
    sum_o.frag = frag_d;
    sum_o.next_hdr = nh_d;
    sum_o.ext_count = cnt_d;
    sum_o.ext_end = ee_d;
    sum_o.trans_start = ts_d;
    sum_o.tcp_bytes = tcp_d;
    sum_o.addr = addr_d;
    sum_o.ports = port_d;
    // frame state clears after the last byte
    if (byte_valid_i && byte_i.last) begin
      fl_d = '0; err_d = 1'b0; ph_d = 1'b0; idx_d = '0; et_d = '0; ep_d = '0;
      ns_d = '0; ihl_d = '0; nh_d = '0; pend_d = '0; tcp_d = '0; vlan_d = '0;
      iplen_d = '0; frag_d = '0; ee_d = Ipv6HdrBytes; ts_d = '0; cnt_d = '0;
      addr_d = '0; port_d = '0;
    end
  end

  assign sum_valid_o = byte_valid_i && byte_i.last;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0; fl_q <= '0; err_q <= 1'b0; ph_q <= 1'b0; idx_q <= '0;
      et_q <= '0; ep_q <= '0; ns_q <= '0; ihl_q <= '0; nh_q <= '0;
      pend_q <= '0; tcp_q <= '0; vlan_q <= '0; iplen_q <= '0; frag_q <= '0;
      ee_q <= Ipv6HdrBytes; ts_q <= '0; cnt_q <= '0; addr_q <= '0;
      port_q <= '0;
    end else begin
      link_q <= link_d; fl_q <= fl_d; err_q <= err_d; ph_q <= ph_d;
      idx_q <= idx_d; et_q <= et_d; ep_q <= ep_d; ns_q <= ns_d;
      ihl_q <= ihl_d; nh_q <= nh_d; pend_q <= pend_d; tcp_q <= tcp_d;
      vlan_q <= vlan_d; iplen_q <= iplen_d; frag_q <= frag_d; ee_q <= ee_d;
      ts_q <= ts_d; cnt_q <= cnt_d; addr_q <= addr_d; port_q <= port_d;
    end
  end

endmodule

/* rtl/core/php_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// php_queue
// Two-entry queue of frame summaries between parser and result stage.
// ----------------------------------------------------------------------------
module php_queue import php_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  php_sum_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output php_sum_t data_o
);

  php_sum_t mem_q [2];
  logic wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  assign data_o = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("summary queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o)) else $error("summary queue underflow");
  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("summary queue level out of range");

endmodule

/* rtl/core/php_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// php_back
// Result stage: length and protocol checks on a frame summary, result word
// held in an output register.
// ----------------------------------------------------------------------------
module php_back import php_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic sum_valid_i,
  input  php_sum_t sum_i,
  output logic sum_pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output php_out_t out_data_o
);

  logic out_valid_q;
  php_out_t out_q, res;

  // final checks
  always_comb begin
    php_status_e st;
    logic [15:0] n, l4, hsz, avail, nm40, used, ts, pay;
    logic v6, is_tcp, is_udp;
    st = StOk;
    n = sum_i.byte_index - {8'd0, sum_i.net_start};
    l4 = '0;
    hsz = '0;
    v6 = 1'b0;
    ts = sum_i.trans_start;
    nm40 = n - Ipv6HdrBytes;
    avail = (sum_i.ip_len < nm40) ? sum_i.ip_len : nm40;
    used = sum_i.ext_end - Ipv6HdrBytes;
    is_tcp = (sum_i.next_hdr == PrTcp);
    is_udp = (sum_i.next_hdr == PrUdp);
    if (sum_i.err) st = StTruncated;
    else if (!sum_i.phase || sum_i.byte_index < {8'd0, sum_i.net_start}) st = StTruncated;
    else if (sum_i.ethertype == EtIpv4) begin
      if (n < 16'd20) st = StTruncated;
      else if (sum_i.ihl_bytes < 8'd20) st = StBadLength;
      else if (n < {8'd0, sum_i.ihl_bytes}) st = StTruncated;
      else if (sum_i.ip_len > n) st = StTruncated;
      else if (sum_i.ip_len < {8'd0, sum_i.ihl_bytes}) st = StBadLength;
      else if (sum_i.frag[13:0] != 14'd0) st = StFragment;
      else if (!is_tcp && !is_udp) st = StProtocol;
      else l4 = sum_i.ip_len - {8'd0, sum_i.ihl_bytes};
    end else if (sum_i.ethertype == EtIpv6) begin
      v6 = 1'b1;
      if (n < Ipv6HdrBytes) st = StTruncated;
      else if (sum_i.ext_end > n) st = StTruncated;
      else if (!is_tcp && !is_udp) begin
        st = (is_ext_hdr(sum_i.next_hdr) && sum_i.ext_count < 4'(MaxExtHeaders))
             ? StTruncated : StProtocol;
      end else if (used > avail) st = StBadLength;
      else begin
        l4 = avail - used;
        ts = sum_i.ext_end;
      end
    end else begin
      st = StUnsupported;
    end
    // transport header size
    if (st == StOk) begin
      if (is_tcp) begin
        hsz = {8'd0, sum_i.tcp_bytes};
        if (l4 < 16'd20 || hsz < 16'd20 || l4 < hsz) st = StBadLength;
      end else begin
        hsz = 16'd8;
        if (l4 < 16'd8) st = StBadLength;
      end
    end
    pay = l4 - hsz;
    if (st == StOk && pay == 16'd0) st = StEmpty;
    res = '0;
    res.status = st;
    if (st == StOk) begin
      res.is_ipv6 = v6;
      res.is_udp = is_udp;
      res.src_addr_high = sum_i.addr[0];
      res.src_addr_low = sum_i.addr[1];
      res.dst_addr_high = sum_i.addr[2];
      res.dst_addr_low = sum_i.addr[3];
      res.source_port = sum_i.ports[0];
      res.dest_port = sum_i.ports[1];
      res.payload_offset = {8'd0, sum_i.net_start} + ts + hsz;
      res.payload_length = pay;
    end
  end

  assign sum_pop_o = sum_valid_i && (!out_valid_q || out_ready_i);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sum_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_pop_o) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != StOk) |->
      (out_q.src_addr_low == 64'd0 && out_q.payload_length == 16'd0))
    else $error("failed frame carries payload fields");
  a_ok_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == StOk) |-> out_q.payload_length != 16'd0)
    else $error("ok result with empty payload");
  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_pop_o |=> out_valid_q) else $error("popped summary not loaded");

endmodule

/* rtl/core/packet_header_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_header_parser
// Ethernet / cooked / raw IP, IPv4 or IPv6, TCP or UDP header parser.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle back to back; each frame's summary enters
// the queue on the clock edge that takes its last byte and moves on into
// the output register once that register is free or being read. The byte
// parser stalls only when the two-entry summary queue is full, which
// happens when results are not taken and two frame ends are waiting.
// link_type is written through the cfg channel, which is always ready,
// and is sampled on the first byte of each frame.
module packet_header_parser import php_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [1:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  php_in_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output php_out_t out_data_o
);

  logic byte_take, sum_valid, q_full, q_valid, q_pop;
  php_sum_t sum, q_data;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = !q_full;
  assign byte_take = in_valid_i && in_ready_o;

  php_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_data_i(cfg_data_i),
    .byte_valid_i(byte_take), .byte_i(in_data_i),
    .sum_valid_o(sum_valid), .sum_o(sum)
  );

  php_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push_i(sum_valid), .push_data_i(sum), .full_o(q_full),
    .pop_i(q_pop), .valid_o(q_valid), .data_o(q_data)
  );

  php_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .sum_valid_i(q_valid), .sum_i(q_data), .sum_pop_o(q_pop),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the packet header parser. Frames are built byte by
// byte (all four link types, VLAN tags, IPv4 and IPv6 with extension chains,
// TCP and UDP, plus damaged and cut-short frames) and driven over the input
// channel. A local predictor computes the result of every frame and the
// monitor compares each result word with it, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import php_pkg::*;

  typedef enum logic [1:0] {
    KindByte,
    KindCfg,
    KindDrain
  } job_kind_e;

  typedef struct {
    job_kind_e kind;
    logic [7:0] data;
    logic last;
  } job_t;

  typedef struct {
    php_link_e lk;
    int vlans;
    bit v6;
    logic [7:0] proto;
    logic [3:0] ihl_w;
    logic [15:0] frag;
    int exts;
    logic [15:0] etype_over;
    int pay;
    int cut;
    int len_adj;
    logic [3:0] doff;
  } frame_spec_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  php_in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  php_out_t out_data_o;

  job_t jobs[$];
  php_out_t expected_results[$];
  int fails;
  int words_sent;
  int quiet_cycles;
  logic in_took;
  logic cfg_took;

  // parser state mirrored by the predictor
  php_link_e link_reg;
  int unsigned f_link, b_idx, phase, etype, et_pos, vlans, net_st;
  int unsigned ihl_b, ip_len, frag_w, nh, ext_pend, ext_cnt, ext_end;
  int unsigned tr_st, tcp_b, err;
  int unsigned port_w[2];
  logic [63:0] addr_w[4];

  packet_header_parser dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // ------------------------------------------------------------------ predictor

  function automatic void frame_clear();
    f_link = 0; b_idx = 0; phase = 0; etype = 0; et_pos = 0; vlans = 0;
    net_st = 0; ihl_b = 0; ip_len = 0; frag_w = 0; nh = 0; ext_pend = 0;
    ext_cnt = 0; ext_end = 40; tr_st = 0; tcp_b = 0; err = 0;
    port_w[0] = 0; port_w[1] = 0;
    for (int k = 0; k < 4; k++) addr_w[k] = '0;
  endfunction

  function automatic bit ext_type(int unsigned n);
    return n == NhHopByHop || n == NhRouting || n == NhDestOpt;
  endfunction

  function automatic void transport_take(int unsigned t, int unsigned b);
    if (t < 4) begin
      port_w[t >> 1] = ((port_w[t >> 1] << 8) | b) & 16'hFFFF;
    end else if (t == 12) begin
      tcp_b = (b >> 4) * 4;
    end
  endfunction

  function automatic void parse_byte(int unsigned b);
    int unsigned i;
    int unsigned r;
    i = b_idx;
    // link type is latched on the first byte
    if (i == 0) begin
      f_link = link_reg;
      case (link_reg)
        LinkEthernet: begin net_st = 14; et_pos = 12; end
        LinkCookedV1: begin net_st = 16; et_pos = 14; end
        LinkCookedV2: begin net_st = 20; et_pos = 0; end
        default: begin
          net_st = 0;
          phase = 1;
          etype = ((b >> 4) == 6) ? EtIpv6 : EtIpv4;
        end
      endcase
    end
    // link header and vlan tags
    if (phase == 0) begin
      if (i == et_pos) etype = b << 8;
      else if (i == et_pos + 1) etype = etype | b;
      if (i + 1 == net_st) begin
        if (f_link == LinkEthernet && etype == EtVlan && vlans < MaxVlanTags) begin
          vlans++;
          net_st += 4;
          et_pos += 4;
        end else begin
          phase = 1;
        end
      end
      return;
    end
    if (i < net_st) return;
    r = i - net_st;
    if (etype == EtIpv4) begin
      if (r == 0) begin
        ihl_b = (b & 4'hF) * 4;
        tr_st = ihl_b;
      end else if (r == 2 || r == 3) ip_len = ((ip_len << 8) | b) & 16'hFFFF;
      else if (r == 6 || r == 7) frag_w = ((frag_w << 8) | b) & 16'hFFFF;
      else if (r == 9) nh = b;
      else if (r >= 12 && r < 16) addr_w[1] = (addr_w[1] << 8) | b;
      else if (r >= 16 && r < 20) addr_w[3] = (addr_w[3] << 8) | b;
      if (r >= tr_st) transport_take(r - tr_st, b);
    end else if (etype == EtIpv6) begin
      if (r == 4 || r == 5) ip_len = ((ip_len << 8) | b) & 16'hFFFF;
      else if (r == 6) nh = b;
      else if (r >= 8 && r < 40) addr_w[(r - 8) >> 3] = (addr_w[(r - 8) >> 3] << 8) | b;
      // extension chain walk
      if (r >= 40 && ext_type(nh) && ext_cnt < MaxExtHeaders) begin
        if (r == ext_end) begin
          ext_pend = b;
        end else if (r == ext_end + 1) begin
          ext_end += (b + 1) * 8;
          nh = ext_pend;
          ext_cnt++;
        end
      end else if (r >= ext_end && (nh == PrTcp || nh == PrUdp)) begin
        tr_st = ext_end;
        transport_take(r - ext_end, b);
      end
    end
  endfunction

  function automatic void predict_word(int unsigned b, logic last);
    php_status_e st;
    php_out_t res;
    int unsigned n, l4, hsz, pay, avail, used;
    bit v6;
    st = StOk; l4 = 0; hsz = 0; pay = 0; v6 = 0; n = 0;
    if (err == 0) begin
      if (b_idx >= FrameLimit) err = 1;
      else begin
        parse_byte(b);
        b_idx++;
      end
    end
    if (!last) return;
    // decide the frame on its last word
    if (err != 0) st = StTruncated;
    else if (phase == 0 || b_idx < net_st) st = StTruncated;
    else begin
      n = b_idx - net_st;
      if (etype == EtIpv4) begin
        if (n < 20) st = StTruncated;
        else if (ihl_b < 20) st = StBadLength;
        else if (n < ihl_b) st = StTruncated;
        else if (ip_len > n) st = StTruncated;
        else if (ip_len < ihl_b) st = StBadLength;
        else if ((frag_w & 16'h3FFF) != 0) st = StFragment;
        else if (nh != PrTcp && nh != PrUdp) st = StProtocol;
        else l4 = ip_len - ihl_b;
      end else if (etype == EtIpv6) begin
        v6 = 1;
        if (n < 40) st = StTruncated;
        else if (ext_end > n) st = StTruncated;
        else if (nh != PrTcp && nh != PrUdp) begin
          st = (ext_type(nh) && ext_cnt < MaxExtHeaders) ? StTruncated : StProtocol;
        end else begin
          avail = (ip_len < n - 40) ? ip_len : n - 40;
          used = ext_end - 40;
          if (used > avail) st = StBadLength;
          else begin
            l4 = avail - used;
            tr_st = ext_end;
          end
        end
      end else begin
        st = StUnsupported;
      end
      // transport header sizes
      if (st == StOk) begin
        if (nh == PrTcp) begin
          hsz = tcp_b;
          if (l4 < 20 || hsz < 20 || l4 < hsz) st = StBadLength;
        end else begin
          hsz = 8;
          if (l4 < 8) st = StBadLength;
        end
        if (st == StOk) begin
          pay = l4 - hsz;
          if (pay == 0) st = StEmpty;
        end
      end
    end
    res = '0;
    res.status = st;
    if (st == StOk) begin
      res.is_ipv6 = v6;
      res.is_udp = (nh == PrUdp);
      res.src_addr_high = addr_w[0];
      res.src_addr_low = addr_w[1];
      res.dst_addr_high = addr_w[2];
      res.dst_addr_low = addr_w[3];
      res.source_port = port_w[0][15:0];
      res.dest_port = port_w[1][15:0];
      res.payload_offset = 16'(net_st + tr_st + hsz);
      res.payload_length = 16'(pay);
    end
    expected_results.push_back(res);
    frame_clear();
  endfunction

  // accept point: mirror config writes and words into the predictor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_took <= 1'b0;
      cfg_took <= 1'b0;
      link_reg = LinkEthernet;
      frame_clear();
    end else begin
      in_took <= in_valid_i && in_ready_o;
      cfg_took <= cfg_valid_i && cfg_ready_o;
      if (cfg_valid_i && cfg_ready_o) link_reg = php_link_e'(cfg_data_i);
      if (in_valid_i && in_ready_o) predict_word(in_data_i.data_byte, in_data_i.last);
    end
  end

  // ------------------------------------------------------------------ driver

  initial begin
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    out_ready_i = 1'b0;
    words_sent = 0;
    quiet_cycles = 0;
    fails = 0;
  end

  function automatic bit calm();
    return words_sent >= 400 && words_sent < 650;
  endfunction

  always @(negedge clk_i) begin
    job_t jb;
    logic nv_in;
    logic nv_cfg;
    if (rst_ni) begin
      nv_in = in_valid_i && !in_took;
      nv_cfg = cfg_valid_i && !cfg_took;
      if (!nv_in && !nv_cfg && jobs.size() > 0) begin
        jb = jobs[0];
        case (jb.kind)
          KindByte: begin
            if (calm() || $urandom_range(99) >= 9) begin
              nv_in = 1'b1;
              in_data_i <= '{data_byte: jb.data, last: jb.last};
              void'(jobs.pop_front());
              words_sent++;
            end
          end
          KindCfg: begin
            nv_cfg = 1'b1;
            cfg_data_i <= jb.data[1:0];
            void'(jobs.pop_front());
          end
          default: begin
            // hold off until every result is back and the pipe settles
            if (expected_results.size() != 0) quiet_cycles = 0;
            else if (quiet_cycles >= 8) begin
              quiet_cycles = 0;
              void'(jobs.pop_front());
            end else quiet_cycles++;
          end
        endcase
      end
      in_valid_i <= nv_in;
      cfg_valid_i <= nv_cfg;
      out_ready_i <= calm() || $urandom_range(99) >= 9;
    end
  end

  // ------------------------------------------------------------------ monitor

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    php_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result word with no frame outstanding");
        fails++;
      end else begin
        e = expected_results.pop_front();
        check_field("status", e.status, out_data_o.status);
        check_field("is_ipv6", e.is_ipv6, out_data_o.is_ipv6);
        check_field("is_udp", e.is_udp, out_data_o.is_udp);
        check_field("src_addr_high", e.src_addr_high, out_data_o.src_addr_high);
        check_field("src_addr_low", e.src_addr_low, out_data_o.src_addr_low);
        check_field("dst_addr_high", e.dst_addr_high, out_data_o.dst_addr_high);
        check_field("dst_addr_low", e.dst_addr_low, out_data_o.dst_addr_low);
        check_field("source_port", e.source_port, out_data_o.source_port);
        check_field("dest_port", e.dest_port, out_data_o.dest_port);
        check_field("payload_offset", e.payload_offset, out_data_o.payload_offset);
        check_field("payload_length", e.payload_length, out_data_o.payload_length);
      end
    end
  end

  // ------------------------------------------------------------------ frames

  task automatic push_word(logic [7:0] d, logic last);
    jobs.push_back('{kind: KindByte, data: d, last: last});
  endtask

  task automatic push_cfg(php_link_e lk);
    jobs.push_back('{kind: KindDrain, data: 8'h00, last: 1'b0});
    jobs.push_back('{kind: KindCfg, data: {6'd0, lk}, last: 1'b0});
  endtask

  function automatic frame_spec_t typical_spec(php_link_e lk);
    frame_spec_t s;
    s.lk = lk;
    s.vlans = (lk == LinkEthernet && $urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    s.v6 = $urandom_range(1);
    s.proto = ($urandom_range(9) == 0) ? 8'($urandom) : ($urandom_range(1) ? PrUdp : PrTcp);
    s.ihl_w = ($urandom_range(6) == 0) ? 4'($urandom) : 4'd5;
    s.frag = ($urandom_range(5) == 0) ? 16'($urandom) : ($urandom_range(1) ? 16'h4000 : 16'h0);
    s.exts = ($urandom_range(12) == 0) ? 9 : $urandom_range(0, 3);
    s.etype_over = ($urandom_range(19) == 0) ? 16'($urandom) : 16'h0;
    s.pay = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 12);
    s.cut = ($urandom_range(5) == 0) ? $urandom_range(1, 90) : -1;
    s.len_adj = ($urandom_range(6) == 0) ? $urandom_range(0, 16) - 8 : 0;
    s.doff = ($urandom_range(6) == 0) ? 4'($urandom) : (($urandom_range(3) == 0) ? 4'd6 : 4'd5);
    return s;
  endfunction

  task automatic push_frame(frame_spec_t s);
    logic [7:0] fb[$];
    logic [7:0] l4[$];
    logic [15:0] et;
    logic [7:0] first_nh;
    int hb, ihlb, span, hl;
    // transport header and payload
    if (s.proto == PrTcp) begin
      hb = (s.doff >= 5) ? s.doff * 4 : 20;
      for (int k = 0; k < hb; k++) l4.push_back((k == 12) ? {s.doff, 4'($urandom)} : 8'($urandom));
    end else begin
      for (int k = 0; k < 8; k++) l4.push_back(8'($urandom));
    end
    for (int k = 0; k < s.pay; k++) l4.push_back(8'($urandom));
    // link header
    et = (s.etype_over != 0) ? s.etype_over : (s.v6 ? EtIpv6 : EtIpv4);
    case (s.lk)
      LinkEthernet: begin
        for (int k = 0; k < 12; k++) fb.push_back(8'($urandom));
        for (int k = 0; k < s.vlans; k++) begin
          fb.push_back(EtVlan[15:8]); fb.push_back(EtVlan[7:0]);
          fb.push_back(8'($urandom)); fb.push_back(8'($urandom));
        end
        fb.push_back(et[15:8]); fb.push_back(et[7:0]);
      end
      LinkCookedV1: begin
        for (int k = 0; k < 14; k++) fb.push_back(8'($urandom));
        fb.push_back(et[15:8]); fb.push_back(et[7:0]);
      end
      LinkCookedV2: begin
        fb.push_back(et[15:8]); fb.push_back(et[7:0]);
        for (int k = 0; k < 18; k++) fb.push_back(8'($urandom));
      end
      default: ;
    endcase
    if (!s.v6) begin
      ihlb = (s.ihl_w >= 5) ? s.ihl_w * 4 : 20;
      et = 16'(ihlb + l4.size() + s.len_adj);
      fb.push_back({4'h4, s.ihl_w}); fb.push_back(8'($urandom));
      fb.push_back(et[15:8]); fb.push_back(et[7:0]);
      fb.push_back(8'($urandom)); fb.push_back(8'($urandom));
      fb.push_back(s.frag[15:8]); fb.push_back(s.frag[7:0]);
      fb.push_back(8'($urandom)); fb.push_back(s.proto);
      for (int k = 10; k < ihlb; k++) fb.push_back(8'($urandom));
    end else begin
      // extension chain first so the payload length covers it
      first_nh = (s.exts > 0) ? NhRouting : s.proto;
      span = 0;
      for (int k = 0; k < s.exts; k++) span += 8 * ($urandom_range(1) + 1);
      et = 16'(span + l4.size() + s.len_adj);
      fb.push_back({4'h6, 4'($urandom)});
      for (int k = 0; k < 3; k++) fb.push_back(8'($urandom));
      fb.push_back(et[15:8]); fb.push_back(et[7:0]);
      fb.push_back(first_nh); fb.push_back(8'($urandom));
      for (int k = 0; k < 32; k++) fb.push_back(8'($urandom));
      for (int k = 0; k < s.exts; k++) begin
        hl = $urandom_range(1);
        case ($urandom_range(2))
          0: first_nh = NhHopByHop;
          1: first_nh = NhRouting;
          default: first_nh = NhDestOpt;
        endcase
        fb.push_back((k == s.exts - 1) ? s.proto : first_nh);
        fb.push_back(8'(hl));
        for (int j = 2; j < (hl + 1) * 8; j++) fb.push_back(8'($urandom));
      end
    end
    foreach (l4[k]) fb.push_back(l4[k]);
    if ($urandom_range(9) == 0) repeat ($urandom_range(1, 6)) fb.push_back(8'($urandom));
    if (s.cut > 0 && s.cut < fb.size()) fb = fb[0:s.cut-1];
    foreach (fb[k]) push_word(fb[k], k == fb.size() - 1);
  endtask

  // ------------------------------------------------------------------ stimulus

  initial begin
    frame_spec_t s;
    php_link_e order[5] = '{LinkRawIp, LinkCookedV1, LinkCookedV2, LinkEthernet, LinkRawIp};
    // directed: extremes and the listed corner cases on ethernet
    push_cfg(LinkEthernet);
    push_word(8'hFF, 1'b1);                       // one-word frame
    s = typical_spec(LinkEthernet);
    s.vlans = 0; s.etype_over = 0; s.v6 = 0; s.proto = PrTcp; s.ihl_w = 5;
    s.frag = 0; s.pay = 4; s.cut = -1; s.len_adj = 0; s.doff = 5; s.exts = 0;
    push_frame(s);
    s.proto = PrUdp; push_frame(s);
    s.ihl_w = 15; s.doff = 15; s.proto = PrTcp; push_frame(s);
    s.ihl_w = 3; push_frame(s);                   // header length below minimum
    s.ihl_w = 5; s.doff = 4; push_frame(s);       // data offset below minimum
    s.doff = 5; s.frag = 16'h2000; push_frame(s); // more-fragments flag
    s.frag = 16'h0001; push_frame(s);             // fragment offset
    s.frag = 0; s.proto = 8'hFF; push_frame(s);   // unknown protocol
    s.proto = PrUdp; s.pay = 0; push_frame(s);    // empty payload
    s.pay = 3; s.len_adj = 20; push_frame(s);     // total length past capture
    s.len_adj = -30; push_frame(s);               // total length below header
    s.len_adj = 0; s.vlans = 2; push_frame(s);
    s.vlans = 3; push_frame(s);                   // one tag too many
    s.vlans = 0; s.etype_over = 16'h1234; push_frame(s);
    s.etype_over = 0; s.v6 = 1; s.exts = 0; push_frame(s);
    s.exts = 8; push_frame(s);
    s.exts = 9; push_frame(s);                    // chain too long
    s.exts = 2; s.len_adj = -12; push_frame(s);   // span past payload length
    s.len_adj = 0; s.cut = 50; push_frame(s);     // cut inside IPv6 header
    s.cut = 10; push_frame(s);                    // short link header
    // one short random phase for each entry of order (raw IP twice)
    for (int ph = 0; ph < 5; ph++) begin
      push_cfg(order[ph]);
      if ($urandom_range(1)) push_word(8'($urandom), 1'b1);
      repeat ($urandom_range(1, 2)) begin
        push_frame(typical_spec(order[ph]));
        if ($urandom_range(29) == 0)
          jobs.push_back('{kind: KindDrain, data: 8'h00, last: 1'b0});
      end
    end
    // wind down
    wait (jobs.size() == 0);
    @(posedge clk_i);
    wait (!in_valid_i && expected_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/php_pkg.sv
rtl/core/php_front.sv
rtl/core/php_queue.sv
rtl/core/php_back.sv
rtl/core/packet_header_parser.sv
bench/tb_top.sv
